[rtl/core/seeded_fnv1a_hash_table_insert_core_macros.svh]
// Assertion macros for the seeded FNV-1a hash table insert core.
`ifndef SEEDED_FNV1A_HASH_TABLE_INSERT_CORE_MACROS_SVH
`define SEEDED_FNV1A_HASH_TABLE_INSERT_CORE_MACROS_SVH
`ifndef SYNTH
`define SFH_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define SFH_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define SFH_ASSERT(lbl, clk, rst_n, prop, msg)
`define SFH_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

[rtl/core/sfh_pkg.sv]
// Shared types and constants of the seeded FNV-1a hash table insert core.
package sfh_pkg;

  localparam int unsigned MAX_SLOTS_DEF = 64;
  localparam int unsigned HASH_W        = 32;
  localparam int unsigned CAP_W         = 7;
  localparam int unsigned CFG_W         = 32;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned DIV_BITS      = 4;
  localparam int unsigned DIV_STEPS     = HASH_W / DIV_BITS;

  localparam logic [HASH_W-1:0]    FNV_PRIME  = 32'd16777619;
  localparam logic [7:0]           CASE_SHIFT = 8'd32;
  localparam logic [7:0]           UPPER_A    = 8'h41;
  localparam logic [7:0]           UPPER_Z    = 8'h5A;
  localparam logic [CAP_W-1:0]     CAP_RESET  = 7'd11;

  localparam logic [CFG_IDX_W-1:0] CFG_SEED     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ICASE    = 2'd2;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       byte_valid;
    logic       last;
  } in_word_t;

  typedef struct packed {
    logic [31:0] hash_value;
    logic [5:0]  slot_index;
    logic        inserted;
    logic [6:0]  entries_used;
  } out_word_t;

  typedef struct packed {
    logic              start;
    logic [HASH_W-1:0] dividend;
    logic [CAP_W-1:0]  divisor;
  } rem_req_t;

  typedef struct packed {
    logic             done;
    logic [CAP_W-1:0] remainder;
  } rem_rsp_t;

  typedef enum logic [3:0] {
    ST_CLEAR  = 4'b0001,
    ST_IDLE   = 4'b0010,
    ST_DIV    = 4'b0100,
    ST_UPDATE = 4'b1000
  } state_e;

endpackage

[rtl/core/sfh_ram.sv]
// Generic single-port-write, registered-read RAM.
module sfh_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/sfh_rem.sv]
// Iterative remainder unit: 32-bit hash modulo a 7-bit divisor, four bits a cycle.
module sfh_rem
  import sfh_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  rem_req_t req_i,
  output rem_rsp_t rsp_o
);

  localparam int unsigned CNT_W = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  logic [HASH_W-1:0] dvd_q;
  logic [CAP_W-1:0]  dvs_q;
  logic [CAP_W-1:0]  rem_q, rem_d;
  logic [CNT_W-1:0]  cnt_q;
  logic              busy_q;
  logic              done_q;

  always_comb begin
    logic [CAP_W:0]   t;
    logic [CAP_W-1:0] r;
    r = rem_q;
    for (int k = 0; k < DIV_BITS; k++) begin
      t = {r, dvd_q[HASH_W-1-k]};
      if (t >= {1'b0, dvs_q}) begin
        t = t - {1'b0, dvs_q};
      end
      r = t[CAP_W-1:0];
    end
    rem_d = r;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= dvd_q << DIV_BITS;
      rem_q <= rem_d;
    end
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.remainder = rem_q;

endmodule

[rtl/core/seeded_fnv1a_hash_table_insert_core.sv]
// Top level: seeded FNV-1a string hash with single-probe slot insert.
// Throughput: a byte that is not last is taken every cycle while the core is idle; the mixer sets that pace.
// A last byte keeps input ready low through 8 remainder steps of 4 bits, one occupancy RAM
// read and one update; its result word is registered at the update, which waits while a
// stalled receiver holds the output register.
// Reset: seed 0, capacity 11, ignore_case 0, count 0; input held off while all MAX_SLOTS slots are cleared.
module seeded_fnv1a_hash_table_insert_core
  import sfh_pkg::*;
#(
  parameter int unsigned MAX_SLOTS = MAX_SLOTS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_word_t             in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_word_t            out_word_o
);

`include "seeded_fnv1a_hash_table_insert_core_macros.svh"

  localparam int unsigned SLOT_W  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int unsigned CNT_W   = $clog2(MAX_SLOTS + 1);
  localparam int unsigned CAP_MAX = (MAX_SLOTS > 127) ? 127 : MAX_SLOTS;

  state_e state_q, state_d;

  logic [HASH_W-1:0] seed_q;
  logic [CAP_W-1:0]  cap_q;
  logic              icase_q;

  logic [HASH_W-1:0] acc_q;
  logic              mid_q;
  logic [HASH_W-1:0] hash_q;
  logic [CAP_W-1:0]  slot_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [SLOT_W-1:0] clr_q;

  logic              out_valid_q;
  out_word_t         out_q;

  logic              in_acc;
  logic              out_free;
  logic              upd_go;
  logic              cnt_inc;
  logic [7:0]        fold_b;
  logic [HASH_W-1:0] base;
  logic [HASH_W-1:0] mix;
  logic [HASH_W-1:0] final_hash;
  logic [CAP_W-1:0]  cap_eff;
  logic              ok;

  rem_req_t          rem_req;
  rem_rsp_t          rem_rsp;

  logic              ram_we;
  logic [SLOT_W-1:0] ram_waddr;
  logic [0:0]        ram_wdata;
  logic              ram_re;
  logic [SLOT_W-1:0] ram_raddr;
  logic [0:0]        ram_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q  <= '0;
      cap_q   <= CAP_RESET;
      icase_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SEED:     seed_q  <= cfg_wdata_i;
        CFG_CAPACITY: cap_q   <= cfg_wdata_i[CAP_W-1:0];
        CFG_ICASE:    icase_q <= cfg_wdata_i[0];
        default:      ;
      endcase
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign upd_go     = (state_q == ST_UPDATE) && out_free;
  assign cnt_inc    = upd_go && ok && (cnt_q != CNT_W'(MAX_SLOTS));

  assign fold_b = (icase_q && in_word_i.char_byte >= UPPER_A && in_word_i.char_byte <= UPPER_Z)
                ? in_word_i.char_byte + CASE_SHIFT : in_word_i.char_byte;
  assign base       = mid_q ? acc_q : seed_q;
  assign mix        = (base ^ {24'd0, fold_b}) * FNV_PRIME;
  assign final_hash = in_word_i.byte_valid ? mix : base;

  assign cap_eff = (cap_q == '0) ? CAP_W'(1)
                 : (cap_q > CAP_W'(CAP_MAX)) ? CAP_W'(CAP_MAX) : cap_q;

  assign rem_req.start    = in_acc && in_word_i.last;
  assign rem_req.dividend = final_hash;
  assign rem_req.divisor  = cap_eff;

  sfh_rem u_rem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (rem_req),
    .rsp_o  (rem_rsp)
  );

  assign ok = !ram_rdata[0];

  always_comb begin
    state_d   = state_q;
    ram_we    = 1'b0;
    ram_waddr = SLOT_W'(slot_q);
    ram_wdata = 1'b1;
    ram_re    = 1'b0;
    ram_raddr = SLOT_W'(rem_rsp.remainder);
    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = 1'b0;
        if (clr_q == SLOT_W'(MAX_SLOTS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (rem_req.start) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (rem_rsp.done) begin
          ram_re  = 1'b1;
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (out_free) begin
          ram_we  = ok;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  sfh_ram #(
    .WIDTH (1),
    .DEPTH (MAX_SLOTS)
  ) u_occ_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      mid_q       <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (in_acc) begin
        if (in_word_i.last) begin
          mid_q <= 1'b0;
        end else if (in_word_i.byte_valid) begin
          mid_q <= 1'b1;
        end
      end
      if (upd_go) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cnt_inc) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && in_word_i.byte_valid && !in_word_i.last) begin
      acc_q <= mix;
    end
    if (rem_req.start) begin
      hash_q <= final_hash;
    end
    if (state_q == ST_DIV && rem_rsp.done) begin
      slot_q <= rem_rsp.remainder;
    end
    if (upd_go) begin
      out_q.hash_value   <= hash_q;
      out_q.slot_index   <= slot_q[5:0];
      out_q.inserted     <= ok;
      out_q.entries_used <= cnt_inc ? 7'(cnt_q + 1'b1) : 7'(cnt_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  `SFH_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= CNT_W'(MAX_SLOTS), "count above slot total")
  `SFH_ASSERT_IMPL(a_out_src, clk_i, rst_ni, $rose(out_valid_q), $past(upd_go), "stray result")
  `SFH_ASSERT_IMPL(a_cnt_step, clk_i, rst_ni, cnt_q != $past(cnt_q), $past(cnt_inc), "stray count")
  `SFH_ASSERT_IMPL(a_rd_bound, clk_i, rst_ni, ram_re, rem_rsp.remainder < cap_eff, "slot too high")

endmodule
